// ===== hdl/quadtree_bitmap_decoder_unit_assert.svh =====
// Assertion macros for the quadtree bitmap decoder.
`ifndef QUADTREE_BITMAP_DECODER_UNIT_ASSERT_SVH
`define QUADTREE_BITMAP_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quadtree decoder check failed");

// next-cycle implication, disabled during reset
`define QBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quadtree decoder check failed");

`endif

// ===== hdl/qbd_pkg.sv =====
// Types, constants and helpers shared by the quadtree bitmap decoder.
package qbd_pkg;

  localparam int MAX_SIDE  = 64;
  localparam int MAX_DEPTH = 6;
  localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;
  localparam int POS_W     = $clog2(MAX_SIDE);
  localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PADDR_W   = 3;

  localparam logic [7:0] CH_OPEN_FULL   = 8'h28;
  localparam logic [7:0] CH_CLOSE_FULL  = 8'h29;
  localparam logic [7:0] CH_OPEN_EMPTY  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_EMPTY = 8'h5D;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0D;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);
  localparam logic              REG_SIDE   = 1'b0;

  typedef enum logic [1:0] {
    MODE_NODE    = 2'd0,
    MODE_PAREN   = 2'd1,
    MODE_BRACKET = 2'd2,
    MODE_CLOSE   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                       mode;
    logic [LEVEL_W-1:0]          level;
    logic [MAX_DEPTH-1:0][1:0]   stack;
    logic                        done;
    logic                        err;
  } parse_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic              region_valid;
    logic [POS_W-1:0]  region_row;
    logic [POS_W-1:0]  region_col;
    logic [SIDE_W-1:0] region_size;
    logic              fill_value;
    logic              done_res;
    logic              error;
  } out_t;

  localparam parse_t PARSE_CLEAR = '{mode: MODE_NODE, level: '0, stack: '0,
                                     done: 1'b0, err: 1'b0};

  // clamp to MAX_SIDE, round down to a power of two, zero reads as one
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] p;
    p = SIDE_W'(1);
    if (s >= SIDE_W'(MAX_SIDE)) begin
      p = SIDE_W'(MAX_SIDE);
    end else begin
      for (int i = 0; i < SIDE_W; i++) begin
        if (s[i]) p = SIDE_W'(1) << i;
      end
    end
    return p;
  endfunction

endpackage

// ===== hdl/qbd_step.sv =====
// One parse step: next parse state and the region word for one character.
module qbd_step (
  input  qbd_pkg::parse_t          cur,
  input  qbd_pkg::in_t             din,
  input  logic [qbd_pkg::SIDE_W-1:0] side,
  output qbd_pkg::parse_t          nxt,
  output qbd_pkg::out_t            res
);
  import qbd_pkg::*;

  function automatic parse_t finish_node(input parse_t s);
    parse_t            r;
    logic [IDX_W-1:0]  idx;
    r   = s;
    idx = IDX_W'(s.level - LEVEL_W'(1));
    if (s.level == '0 || s.level > LEVEL_W'(MAX_DEPTH)) begin
      r.done = 1'b1;
      r.mode = MODE_NODE;
    end else if (s.stack[idx] != 2'd3) begin
      r.stack[idx] = s.stack[idx] + 2'd1;
      r.mode       = MODE_NODE;
    end else begin
      r.stack[idx] = 2'd0;
      r.level      = s.level - LEVEL_W'(1);
      r.mode       = MODE_CLOSE;
    end
    return r;
  endfunction

  function automatic parse_t begin_node(input parse_t s, input logic [7:0] c);
    parse_t r;
    r = s;
    if (c == CH_OPEN_FULL)       r.mode = MODE_PAREN;
    else if (c == CH_OPEN_EMPTY) r.mode = MODE_BRACKET;
    else                         r = finish_node(s);
    return r;
  endfunction

  parse_t            s0;
  parse_t            s1;
  logic              white;
  logic              emit;
  logic              fill;
  logic [SIDE_W-1:0] row_sum;
  logic [SIDE_W-1:0] col_sum;
  logic [SIDE_W-1:0] cur_size;
  logic [IDX_W-1:0]  push_idx;

  always_comb begin
    s0       = din.restart ? PARSE_CLEAR : cur;
    s1       = s0;
    emit     = 1'b0;
    fill     = 1'b0;
    white    = (din.char_code == CH_SPACE) ||
               (din.char_code >= CH_TAB && din.char_code <= CH_CR);
    cur_size = side >> s0.level;
    push_idx = IDX_W'(s0.level);

    if (!s0.done && !s0.err && !white) begin
      unique case (s0.mode)
        MODE_NODE: s1 = begin_node(s0, din.char_code);
        MODE_PAREN: begin
          if (din.char_code == CH_CLOSE_FULL) begin
            emit = 1'b1;
            fill = 1'b1;
            s1   = finish_node(s0);
          end else if (s0.level >= LEVEL_W'(MAX_DEPTH) || cur_size <= SIDE_W'(1)) begin
            s1.err = 1'b1;
          end else begin
            s1                 = s0;
            s1.stack[push_idx] = 2'd0;
            s1.level           = s0.level + LEVEL_W'(1);
            s1.mode            = MODE_NODE;
            s1                 = begin_node(s1, din.char_code);
          end
        end
        MODE_BRACKET: begin
          if (din.char_code == CH_CLOSE_EMPTY) begin
            emit = 1'b1;
            s1   = finish_node(s0);
          end else begin
            // unmatched bracket: leaf ends unfilled, char is reparsed
            s1 = finish_node(s0);
            if (!s1.done) begin
              if (s1.mode == MODE_NODE) s1 = begin_node(s1, din.char_code);
              else                      s1 = finish_node(s1);
            end
          end
        end
        MODE_CLOSE: s1 = finish_node(s0);
        default:    s1 = s0;
      endcase
    end

    // leaf position from the quadrant path
    row_sum = '0;
    col_sum = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LEVEL_W'(i) < s0.level) begin
        if (s0.stack[i][1]) row_sum = row_sum + (side >> (i + 1));
        if (s0.stack[i][0]) col_sum = col_sum + (side >> (i + 1));
      end
    end
  end

  assign nxt              = s1;
  assign res.region_valid = emit;
  assign res.region_row   = emit ? row_sum[POS_W-1:0] : '0;
  assign res.region_col   = emit ? col_sum[POS_W-1:0] : '0;
  assign res.region_size  = emit ? cur_size : '0;
  assign res.fill_value   = emit & fill;
  assign res.done_res     = s1.done;
  assign res.error        = s1.err;

endmodule

// ===== hdl/quadtree_bitmap_decoder_unit.sv =====
// Quadtree bitmap decoder top level: parse state, result register, config port.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  char     | char_valid / char_stall  | char_word: char_code, restart
//  res      | res_valid / res_stall    | res_word: region record, done, error
//  config   | psel/penable/pwrite      | paddr, pwdata, prdata (side_length)
//
// One character per cycle while char_stall is low; each accepted word yields
// exactly one result word, registered in the next cycle by the single parse
// step between state and result. Reset (rst, synchronous) clears parse state
// and sets side_length to 8. A waiting result stalls input only while res_stall
// is held; the result register is taken and refilled in the same cycle.
module quadtree_bitmap_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          char_valid,
  output logic                          char_stall,
  input  qbd_pkg::in_t                  char_word,
  output logic                          res_valid,
  input  logic                          res_stall,
  output qbd_pkg::out_t                 res_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import qbd_pkg::*;

  `include "quadtree_bitmap_decoder_unit_assert.svh"

  parse_t            st;
  parse_t            st_next;
  out_t              step_res;
  logic [SIDE_W-1:0] side_length;
  logic [SIDE_W-1:0] side_eff;
  logic              accept;
  logic              cfg_wr;

  assign char_stall = res_valid & res_stall;
  assign accept     = char_valid & ~char_stall;
  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_SIDE);
  assign prdata     = (paddr[PADDR_W-1] == REG_SIDE) ? 32'(side_length) : '0;

  qbd_step u_step (
    .cur  (st),
    .din  (char_word),
    .side (side_eff),
    .nxt  (st_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= PARSE_CLEAR;
      res_valid   <= 1'b0;
      side_length <= SIDE_RESET;
      side_eff    <= eff_side(SIDE_RESET);
    end else begin
      if (cfg_wr) begin
        side_length <= pwdata[SIDE_W-1:0];
        side_eff    <= eff_side(pwdata[SIDE_W-1:0]);
      end
      if (accept) begin
        st        <= st_next;
        res_valid <= 1'b1;
        res_word  <= step_res;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `QBD_ASSERT_NOW(a_level_range, clk, rst, 1'b1, st.level <= LEVEL_W'(MAX_DEPTH))
  `QBD_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, res_valid)
  `QBD_ASSERT_NEXT(a_done_sticky, clk, rst, st.done && !(accept && char_word.restart), st.done)
  `QBD_ASSERT_NOW(a_idle_fields, clk, rst, res_valid && !res_word.region_valid, res_word.region_size == '0 && !res_word.fill_value)

endmodule

// ===== tb/region_checker.sv =====
// Checker for the quadtree decoder: predicts each region word and compares it.
`timescale 1ns / 1ps
module region_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  input  logic                        char_stall,
  input  qbd_pkg::in_t                char_word,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  qbd_pkg::out_t               res_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [qbd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);
  import qbd_pkg::*;

  localparam logic [PADDR_W-1:0] SIDE_ADDR = PADDR_W'(4 * REG_SIDE);

  logic [SIDE_W-1:0] side_reg;
  mode_t             pmode;
  int                depth;
  logic [1:0]        quad_at [MAX_DEPTH];
  logic              done_f;
  logic              err_f;
  out_t              region_q [$];

  function automatic int used_side();
    int s;
    int p;
    s = side_reg;
    if (s > MAX_SIDE) s = MAX_SIDE;
    p = 1;
    while (p * 2 <= s) p = p * 2;
    return p;
  endfunction

  task automatic clear_tree();
    pmode = MODE_NODE;
    depth = 0;
    for (int i = 0; i < MAX_DEPTH; i++) quad_at[i] = 2'd0;
    done_f = 1'b0;
    err_f = 1'b0;
  endtask

  // step to the next sibling, pop a level once the fourth child is done, or finish at the root
  task automatic close_node();
    if (depth == 0 || depth > MAX_DEPTH) begin
      done_f = 1'b1;
      pmode = MODE_NODE;
    end else if (quad_at[depth-1] != 2'd3) begin
      quad_at[depth-1] = quad_at[depth-1] + 2'd1;
      pmode = MODE_NODE;
    end else begin
      quad_at[depth-1] = 2'd0;
      depth = depth - 1;
      pmode = MODE_CLOSE;
    end
  endtask

  task automatic open_node(input logic [7:0] c);
    if (c == CH_OPEN_FULL) begin
      pmode = MODE_PAREN;
    end else if (c == CH_OPEN_EMPTY) begin
      pmode = MODE_BRACKET;
    end else begin
      close_node();
    end
  endtask

  function automatic out_t leaf_region(input logic fill);
    out_t r;
    int   side;
    int   row;
    int   col;
    int   half;
    side = used_side();
    row = 0;
    col = 0;
    for (int i = 0; i < depth; i++) begin
      half = side >> (i + 1);
      if (quad_at[i][1]) row += half;
      if (quad_at[i][0]) col += half;
    end
    r = '0;
    r.region_valid = 1'b1;
    r.region_row = POS_W'(row);
    r.region_col = POS_W'(col);
    r.region_size = SIDE_W'(side >> depth);
    r.fill_value = fill;
    return r;
  endfunction

  task automatic decode_step(input in_t w, output out_t r);
    logic [7:0] c;
    logic       ws;
    c = w.char_code;
    r = '0;
    ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    if (w.restart) clear_tree();
    if (!done_f && !err_f && !ws) begin
      case (pmode)
        MODE_NODE: begin
          open_node(c);
        end
        MODE_PAREN: begin
          if (c == CH_CLOSE_FULL) begin
            r = leaf_region(1'b1);
            close_node();
          end else if (depth >= MAX_DEPTH || (used_side() >> depth) <= 1) begin
            err_f = 1'b1;
          end else begin
            quad_at[depth] = 2'd0;
            depth = depth + 1;
            pmode = MODE_NODE;
            open_node(c);
          end
        end
        MODE_BRACKET: begin
          if (c == CH_CLOSE_EMPTY) begin
            r = leaf_region(1'b0);
            close_node();
          end else begin
            // lone bracket: node ends empty, char is reused
            close_node();
            if (!done_f) begin
              if (pmode == MODE_NODE) open_node(c);
              else close_node();
            end
          end
        end
        default: begin
          close_node();
        end
      endcase
    end
    r.done_res = done_f;
    r.error = err_f;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
    end
  endfunction

  // push before pop so a same-edge result still meets the older word
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (rst) begin
      side_reg = SIDE_RESET;
      clear_tree();
      region_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SIDE_ADDR) begin
        side_reg = pwdata[SIDE_W-1:0];
      end
      if (char_valid && !char_stall) begin
        decode_step(char_word, want);
        region_q.push_back(want);
      end
      if (res_valid && !res_stall) begin
        got = res_word;
        if (region_q.size() == 0) begin
          fail_count++;
          $error("result word with no region expected");
        end else begin
          want = region_q.pop_front();
          check_field("region_valid", 32'(want.region_valid), 32'(got.region_valid));
          check_field("region_row", 32'(want.region_row), 32'(got.region_row));
          check_field("region_col", 32'(want.region_col), 32'(got.region_col));
          check_field("region_size", 32'(want.region_size), 32'(got.region_size));
          check_field("fill_value", 32'(want.fill_value), 32'(got.fill_value));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
          check_field("error", 32'(want.error), 32'(got.error));
        end
      end
    end
    pending <= region_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the quadtree decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import qbd_pkg::*;

  localparam int                 HOLD_CYCLES  = 64;
  localparam int                 WATCH_LIMIT  = 1000;
  localparam int                 SET_ITEMS    = 140;
  localparam logic [PADDR_W-1:0] SIDE_ADDR    = PADDR_W'(4 * REG_SIDE);

  logic               clk;
  logic               rst;
  logic               char_valid;
  logic               char_stall;
  in_t                char_word;
  logic               res_valid;
  logic               res_stall;
  out_t               res_word;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int         fail_count;
  int         pending;
  int         snd_idle;
  int         rcv_idle;
  logic       hold_req;
  int         sent;
  logic [7:0] text_q [$];
  int         sides [10] = '{64, 8, 1, 127, 0, 37, 2, 16, 32, 4};

  quadtree_bitmap_decoder_unit u_dut (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  region_checker u_checker (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          res_stall <= 1'b1;
          @(negedge clk);
        end
      end
      res_stall <= ($urandom_range(0, 99) < rcv_idle);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCH_LIMIT) begin
      @(posedge clk);
      if (rst || (char_valid && !char_stall) || (res_valid && !res_stall) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int tree_depth(input int v);
    int s;
    int d;
    s = (v > MAX_SIDE) ? MAX_SIDE : v;
    d = 0;
    while ((2 << d) <= s) d++;
    return d;
  endfunction

  function automatic logic [7:0] ws_char();
    if ($urandom_range(0, 1)) return CH_SPACE;
    return 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic rs);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_word <= '{char_code: c, restart: rs};
    sent++;
    do @(posedge clk); while (char_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic drain();
    @(negedge clk);
    char_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_side(input int v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIDE_ADDR;
    pwdata <= (32'($urandom) & ~32'h7F) | 32'(v[6:0]);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // well-formed subtree, now and then with a lone bracket or a stray node char
  task automatic gen_node(input int lvl, input int lim);
    int r;
    if ($urandom_range(0, 9) == 0) text_q.push_back(ws_char());
    r = $urandom_range(0, 99);
    if (lvl < lim && r < 55 - 8 * lvl) begin
      text_q.push_back(CH_OPEN_FULL);
      for (int k = 0; k < 4; k++) gen_node(lvl + 1, lim);
      if ($urandom_range(0, 7) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back(CH_CLOSE_FULL);
    end else if (r < 75) begin
      text_q.push_back(CH_OPEN_FULL);
      text_q.push_back(CH_CLOSE_FULL);
    end else if (r < 95) begin
      text_q.push_back(CH_OPEN_EMPTY);
      text_q.push_back(CH_CLOSE_EMPTY);
    end else if (r < 98) begin
      text_q.push_back(CH_OPEN_EMPTY);
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_tree(input int side);
    int r;
    int lim;
    int n;
    text_q.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      lim = tree_depth(side) + ($urandom_range(0, 19) == 0);
      gen_node(0, lim);
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (text_q[i]) begin
      if (i == 0) send_char(text_q[i], r >= 3);
      else send_char(text_q[i], $urandom_range(0, 99) == 0);
    end
  endtask

  initial begin
    int start;
    rst = 1'b1;
    char_valid = 1'b0;
    char_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    sent = 0;
    snd_idle = 25;
    rcv_idle = 45;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset side of 8
    send_text("()");
    send_text("[](");                 // trailing char after done is ignored
    send_text("(()[][()x");           // lone bracket, unchecked closing char
    send_text("(((( (");              // split below size one
    send_char(8'hFF, 1'b1);           // unknown char as root
    send_char(8'h00, 1'b0);
    send_char(CH_CR, 1'b1);           // restart on whitespace
    send_char(CH_OPEN_EMPTY, 1'b0);
    send_char(CH_CLOSE_EMPTY, 1'b0);
    drain();

    foreach (sides[k]) begin
      write_side(sides[k]);
      if (k < 3) begin
        snd_idle = 25;
        rcv_idle = 45;
      end else if (k < 6) begin
        snd_idle = 45;
        rcv_idle = 25;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (k == 1) hold_req = 1'b1;
      start = sent;
      while (sent - start < SET_ITEMS) random_tree(sides[k]);
      drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
